FILE: sv/dgsp_pkg.sv
package dgsp_pkg;

  localparam int DIST_BITS = 22;
  localparam int KEY_BITS = 24;
  localparam int COUNT_BITS = 7;
  localparam int SOURCE_BITS = 6;
  localparam int END_BITS = 6;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int OUT_INDEX_BITS = 6;

  localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3F_FFFF;
  localparam logic [KEY_BITS-1:0] KEY_UNREACHED = 24'h80_0000;
  localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;
  localparam logic [SOURCE_BITS-1:0] SOURCE_RESET = 6'd0;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_EDGE = 2'd1;
  localparam logic [1:0] FUNC_RUN = 2'd2;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_SOURCE_NODE = 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_EDGE2   = 8'b0000_0100,
    ST_INIT    = 8'b0000_1000,
    ST_SCAN    = 8'b0001_0000,
    ST_DRAIN   = 8'b0010_0000,
    ST_EMIT_RD = 8'b0100_0000,
    ST_EMIT_LD = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic settled;
    logic reached;
    logic [DIST_BITS-1:0] path_len;
  } dist_word_t;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

FILE: sv/dgsp_ram.sv
module dgsp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dgsp_relax.sv
module dgsp_relax #(
  parameter int MAX_NODES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dgsp_pkg::scan_ctl_t                 issue,
  input  logic [$clog2(MAX_NODES)-1:0]        issue_v,
  input  logic [$clog2(MAX_NODES)-1:0]        u_idx,
  input  logic [dgsp_pkg::KEY_BITS-1:0]       u_key,
  input  dgsp_pkg::dist_word_t                rd_word,
  input  logic [WEIGHT_BITS-1:0]              rd_weight,
  output logic                                wr_en,
  output logic [$clog2(MAX_NODES)-1:0]        wr_addr,
  output dgsp_pkg::dist_word_t                wr_word,
  output logic                                busy,
  output logic [$clog2(MAX_NODES)-1:0]        pick_idx,
  output logic [dgsp_pkg::KEY_BITS-1:0]       pick_key
);

  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int SUM_BITS =
    (WEIGHT_BITS > dgsp_pkg::DIST_BITS ? WEIGHT_BITS : dgsp_pkg::DIST_BITS) + 1;

  dgsp_pkg::scan_ctl_t s1_ctl;
  logic [NODE_BITS-1:0] s1_v;
  dgsp_pkg::scan_ctl_t s2_ctl;
  logic [NODE_BITS-1:0] s2_v;
  dgsp_pkg::dist_word_t s2_word;
  logic [dgsp_pkg::KEY_BITS-1:0] best_key;
  logic [NODE_BITS-1:0] best_idx;

  logic [SUM_BITS-1:0] sum;
  logic [dgsp_pkg::DIST_BITS-1:0] sat;
  logic is_u;
  logic relax_ok;
  logic better;
  dgsp_pkg::dist_word_t new_word;
  logic cand;
  logic [dgsp_pkg::KEY_BITS-1:0] cand_key;
  logic [dgsp_pkg::KEY_BITS-1:0] base_key;

  // stage 1: relax against the node being settled, and mark that node settled
  always_comb begin
    sum = SUM_BITS'(u_key[dgsp_pkg::DIST_BITS-1:0]) + SUM_BITS'(rd_weight);
    sat = (sum > SUM_BITS'(dgsp_pkg::DIST_MAX)) ? dgsp_pkg::DIST_MAX
                                                : sum[dgsp_pkg::DIST_BITS-1:0];
    is_u = (s1_v == u_idx);
    relax_ok = !u_key[dgsp_pkg::KEY_BITS-1] && !rd_word.settled && !is_u &&
               (rd_weight != '0);
    better = !rd_word.reached || (sat < rd_word.path_len);
    new_word = rd_word;
    if (is_u) begin
      new_word.settled = 1'b1;
    end
    if (relax_ok && better) begin
      new_word.reached = 1'b1;
      new_word.path_len = sat;
    end
  end

  assign wr_en = s1_ctl.valid && (is_u || (relax_ok && better));
  assign wr_addr = s1_v;
  assign wr_word = new_word;

  // stage 2: minimum search, ties to the highest index
  always_comb begin
    cand = s2_ctl.valid && !s2_word.settled;
    cand_key = s2_word.reached ? dgsp_pkg::KEY_BITS'(s2_word.path_len)
                               : dgsp_pkg::KEY_UNREACHED;
    base_key = s2_ctl.first ? '1 : best_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
    end else begin
      s1_ctl <= issue;
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_v <= issue_v;
    s2_v <= s1_v;
    s2_word <= new_word;
    if (cand && cand_key <= base_key) begin
      best_key <= cand_key;
      best_idx <= s2_v;
    end else if (s2_ctl.valid && s2_ctl.first) begin
      best_key <= '1;
    end
  end

  assign busy = s1_ctl.valid || s2_ctl.valid;
  assign pick_idx = best_idx;
  assign pick_key = best_key;

endmodule

FILE: sv/dense_graph_shortest_paths_top.sv
// Single-source shortest paths over an undirected graph kept as a MAX_NODES x MAX_NODES
// weight matrix in one memory, distances in a second MAX_NODES-deep memory. After reset
// and after every clear transaction the matrix is swept to zero, one entry per cycle,
// all MAX_NODES*MAX_NODES entries, during which no transaction is accepted. An edge write
// writes both matrix words, (a,b) and then (b,a). A run with n nodes initializes the n
// distance words, then runs n-1 rounds, each one pass over the distance memory that
// relaxes the neighbors of the last settled node and finds the next one, then reads each
// result out through ST_EMIT_RD and ST_EMIT_LD, holding while the output is stalled; the
// distance memory port sets the pace. Ties in the pick go to the highest node index.
module dense_graph_shortest_paths_top #(
  parameter int MAX_NODES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // end_a, end_b, edge_weight
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // node_index, path_length
  output logic        m_tuser,   // reachable
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int ADJ_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ADJ_BITS = $clog2(ADJ_DEPTH);

  dgsp_pkg::state_t state;
  logic [ADJ_BITS-1:0] clr_addr;
  logic [NODE_BITS-1:0] v;
  logic [NODE_BITS-1:0] n_last;
  logic [NODE_BITS-1:0] round;
  logic [NODE_BITS-1:0] u_idx;
  logic [dgsp_pkg::KEY_BITS-1:0] u_key;
  logic [NODE_BITS-1:0] edge_a;
  logic [NODE_BITS-1:0] edge_b;
  logic [WEIGHT_BITS-1:0] edge_w;
  logic [dgsp_pkg::COUNT_BITS-1:0] node_count;
  logic [dgsp_pkg::SOURCE_BITS-1:0] source_node;

  logic [dgsp_pkg::END_BITS-1:0] in_a;
  logic [dgsp_pkg::END_BITS-1:0] in_b;
  logic [dgsp_pkg::IN_WEIGHT_BITS-1:0] in_w;
  logic in_fire;
  logic ends_ok;
  logic src_ok;

  logic adj_we;
  logic [ADJ_BITS-1:0] adj_waddr;
  logic [WEIGHT_BITS-1:0] adj_wdata;
  logic [ADJ_BITS-1:0] adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_rdata;

  logic dist_we;
  logic [NODE_BITS-1:0] dist_waddr;
  dgsp_pkg::dist_word_t dist_wdata;
  dgsp_pkg::dist_word_t dist_rdata;
  dgsp_pkg::dist_word_t init_word;

  dgsp_pkg::scan_ctl_t issue;
  logic rx_we;
  logic [NODE_BITS-1:0] rx_waddr;
  dgsp_pkg::dist_word_t rx_wdata;
  logic rx_busy;
  logic [NODE_BITS-1:0] pick_idx;
  logic [dgsp_pkg::KEY_BITS-1:0] pick_key;

  logic out_free;

  assign in_a = s_tdata[5:0];
  assign in_b = s_tdata[11:6];
  assign in_w = s_tdata[27:12];
  assign s_tready = (state == dgsp_pkg::ST_IDLE);
  assign in_fire = s_tvalid && s_tready;
  assign ends_ok = (32'(in_a) < MAX_NODES) && (32'(in_b) < MAX_NODES);
  assign src_ok = 32'(source_node) <= 32'(n_last);
  assign out_free = !m_tvalid || m_tready;

  // adjacency port
  always_comb begin
    adj_we = 1'b0;
    adj_waddr = clr_addr;
    adj_wdata = '0;
    case (state)
      dgsp_pkg::ST_CLEAR: begin
        adj_we = 1'b1;
      end
      dgsp_pkg::ST_IDLE: begin
        adj_we = in_fire && (s_tuser == dgsp_pkg::FUNC_EDGE) && ends_ok;
        adj_waddr = ADJ_BITS'(32'(NODE_BITS'(in_a)) * MAX_NODES + 32'(NODE_BITS'(in_b)));
        adj_wdata = WEIGHT_BITS'(in_w);
      end
      dgsp_pkg::ST_EDGE2: begin
        adj_we = 1'b1;
        adj_waddr = ADJ_BITS'(32'(edge_b) * MAX_NODES + 32'(edge_a));
        adj_wdata = edge_w;
      end
      default: begin
        adj_we = 1'b0;
      end
    endcase
  end

  assign adj_raddr = ADJ_BITS'(32'(u_idx) * MAX_NODES + 32'(v));

  // distance port
  always_comb begin
    init_word.settled = 1'b0;
    init_word.reached = src_ok && (32'(v) == 32'(source_node));
    init_word.path_len = '0;
    if (state == dgsp_pkg::ST_INIT) begin
      dist_we = 1'b1;
      dist_waddr = v;
      dist_wdata = init_word;
    end else begin
      dist_we = rx_we;
      dist_waddr = rx_waddr;
      dist_wdata = rx_wdata;
    end
  end

  assign issue.valid = (state == dgsp_pkg::ST_SCAN);
  assign issue.first = (v == '0);

  dgsp_ram #(
    .DEPTH(ADJ_DEPTH),
    .WIDTH(WEIGHT_BITS)
  ) u_adj_ram (
    .clk(clk),
    .we(adj_we),
    .waddr(adj_waddr),
    .wdata(adj_wdata),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  dgsp_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH($bits(dgsp_pkg::dist_word_t))
  ) u_dist_ram (
    .clk(clk),
    .we(dist_we),
    .waddr(dist_waddr),
    .wdata(dist_wdata),
    .raddr(v),
    .rdata(dist_rdata)
  );

  dgsp_relax #(
    .MAX_NODES(MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_relax (
    .clk(clk),
    .rst(rst),
    .issue(issue),
    .issue_v(v),
    .u_idx(u_idx),
    .u_key(u_key),
    .rd_word(dist_rdata),
    .rd_weight(adj_rdata),
    .wr_en(rx_we),
    .wr_addr(rx_waddr),
    .wr_word(rx_wdata),
    .busy(rx_busy),
    .pick_idx(pick_idx),
    .pick_key(pick_key)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dgsp_pkg::NODE_COUNT_RESET;
      source_node <= dgsp_pkg::SOURCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dgsp_pkg::CFG_NODE_COUNT: node_count <= cfg_data;
        dgsp_pkg::CFG_SOURCE_NODE: source_node <= cfg_data[dgsp_pkg::SOURCE_BITS-1:0];
        default: node_count <= node_count;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgsp_pkg::ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        dgsp_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == ADJ_DEPTH - 1) begin
            state <= dgsp_pkg::ST_IDLE;
          end
        end
        dgsp_pkg::ST_IDLE: begin
          if (in_fire) begin
            case (s_tuser)
              dgsp_pkg::FUNC_CLEAR: begin
                clr_addr <= '0;
                state <= dgsp_pkg::ST_CLEAR;
              end
              dgsp_pkg::FUNC_EDGE: begin
                if (ends_ok) begin
                  state <= dgsp_pkg::ST_EDGE2;
                end
              end
              dgsp_pkg::FUNC_RUN: begin
                v <= '0;
                if (node_count == '0) begin
                  n_last <= '0;
                end else if (32'(node_count) > MAX_NODES) begin
                  n_last <= NODE_BITS'(MAX_NODES - 1);
                end else begin
                  n_last <= NODE_BITS'(node_count - 1'b1);
                end
                state <= dgsp_pkg::ST_INIT;
              end
              default: state <= dgsp_pkg::ST_IDLE;
            endcase
          end
        end
        dgsp_pkg::ST_EDGE2: begin
          state <= dgsp_pkg::ST_IDLE;
        end
        dgsp_pkg::ST_INIT: begin
          if (v == n_last) begin
            v <= '0;
            round <= '0;
            u_idx <= src_ok ? NODE_BITS'(source_node) : n_last;
            u_key <= src_ok ? '0 : dgsp_pkg::KEY_UNREACHED;
            state <= (n_last == '0) ? dgsp_pkg::ST_EMIT_RD : dgsp_pkg::ST_SCAN;
          end else begin
            v <= v + 1'b1;
          end
        end
        dgsp_pkg::ST_SCAN: begin
          if (v == n_last) begin
            state <= dgsp_pkg::ST_DRAIN;
          end else begin
            v <= v + 1'b1;
          end
        end
        dgsp_pkg::ST_DRAIN: begin
          if (!rx_busy) begin
            v <= '0;
            if (round == n_last - 1'b1) begin
              state <= dgsp_pkg::ST_EMIT_RD;
            end else begin
              round <= round + 1'b1;
              u_idx <= pick_idx;
              u_key <= pick_key;
              state <= dgsp_pkg::ST_SCAN;
            end
          end
        end
        dgsp_pkg::ST_EMIT_RD: begin
          if (out_free) begin
            state <= dgsp_pkg::ST_EMIT_LD;
          end
        end
        dgsp_pkg::ST_EMIT_LD: begin
          m_tvalid <= 1'b1;
          if (v == n_last) begin
            state <= dgsp_pkg::ST_IDLE;
          end else begin
            v <= v + 1'b1;
            state <= dgsp_pkg::ST_EMIT_RD;
          end
        end
        default: state <= dgsp_pkg::ST_IDLE;
      endcase
    end
  end

  // edge capture and result register
  always_ff @(posedge clk) begin
    if (in_fire && s_tuser == dgsp_pkg::FUNC_EDGE) begin
      edge_a <= NODE_BITS'(in_a);
      edge_b <= NODE_BITS'(in_b);
      edge_w <= WEIGHT_BITS'(in_w);
    end
    if (state == dgsp_pkg::ST_EMIT_LD) begin
      m_tdata <= {4'b0000,
                  dist_rdata.reached ? dist_rdata.path_len : {dgsp_pkg::DIST_BITS{1'b0}},
                  dgsp_pkg::OUT_INDEX_BITS'(v)};
      m_tuser <= dist_rdata.reached;
      m_tlast <= (v == n_last);
    end
  end

endmodule

FILE: sv/dgsp_checker.sv
module dgsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [6:0]  cfg_data
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result dropped or changed while stalled");

  // matrix sweep follows reset
  a_reset_sweep: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  // clear and run transactions hold off further input
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == dgsp_pkg::FUNC_CLEAR |=> !s_tready)
    else $error("input taken right after clear");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == dgsp_pkg::FUNC_RUN |=> !s_tready)
    else $error("input taken right after run");

  // unreachable nodes report zero length
  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[27:6] == '0)
    else $error("nonzero length on unreachable node");

endmodule

bind dense_graph_shortest_paths_top dgsp_checker u_dgsp_checker (.*);

FILE: tb/tb_dense_graph_shortest_paths_top.sv
`timescale 1ns / 1ps

module tb_dense_graph_shortest_paths_top;

  localparam int MAX_NODES = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int IDLE_LIMIT = 40000;
  localparam int CLEAR_SETTLE = MAX_NODES * MAX_NODES + 16;
  localparam int ITEM_SETTLE = 8;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [dgsp_pkg::OUT_INDEX_BITS-1:0] node;
    logic [dgsp_pkg::DIST_BITS-1:0]      length;
    logic                                reach;
    logic                                last_flag;
  } path_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // end_a, end_b, edge_weight
  logic [1:0]  s_tuser = '0;   // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // node_index, path_length
  logic        m_tuser;        // reachable
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  logic [dgsp_pkg::IN_WEIGHT_BITS-1:0] weight_mat [MAX_NODES][MAX_NODES];
  logic [dgsp_pkg::COUNT_BITS-1:0]     node_count_reg;
  logic [dgsp_pkg::SOURCE_BITS-1:0]    source_reg;
  path_result_t                        expected_paths [$];
  int                                  mismatches = 0;
  int                                  idle_cycles = 0;
  int                                  settle_cycles = ITEM_SETTLE;
  int                                  ready_hold = 0;
  bit                                  quiet_phase = 1'b0;

  dense_graph_shortest_paths_top #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int nodes_in_use();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > MAX_NODES) return MAX_NODES;
    return int'(node_count_reg);
  endfunction

  task automatic clear_graph_model();
    int r, c;
    for (r = 0; r < MAX_NODES; r++)
      for (c = 0; c < MAX_NODES; c++)
        weight_mat[r][c] = '0;
  endtask

  task automatic predict_paths();
    int n, u, v, step;
    logic [dgsp_pkg::DIST_BITS-1:0] best_dist [MAX_NODES];
    logic reach [MAX_NODES];
    logic done [MAX_NODES];
    logic [dgsp_pkg::KEY_BITS:0] best_key, key;
    logic [dgsp_pkg::DIST_BITS:0] sum;
    logic [dgsp_pkg::IN_WEIGHT_BITS-1:0] w;
    path_result_t r;
    n = nodes_in_use();
    for (v = 0; v < MAX_NODES; v++) begin
      best_dist[v] = '0;
      reach[v] = 1'b0;
      done[v] = 1'b0;
    end
    if (source_reg < n) reach[source_reg] = 1'b1;
    for (step = 0; step + 1 < n; step++) begin
      best_key = '1;
      u = 0;
      // unreached nodes rank above any distance, ties go to the higher index
      for (v = 0; v < n; v++) begin
        key = reach[v] ? {3'b000, best_dist[v]} : {1'b0, dgsp_pkg::KEY_UNREACHED};
        if (!done[v] && key <= best_key) begin
          best_key = key;
          u = v;
        end
      end
      done[u] = 1'b1;
      if (!reach[u]) continue;
      for (v = 0; v < n; v++) begin
        w = weight_mat[u][v];
        if (done[v] || w == 0) continue;
        sum = {1'b0, best_dist[u]} + w;
        if (sum > dgsp_pkg::DIST_MAX) sum = {1'b0, dgsp_pkg::DIST_MAX};
        if (!reach[v] || sum[dgsp_pkg::DIST_BITS-1:0] < best_dist[v]) begin
          best_dist[v] = sum[dgsp_pkg::DIST_BITS-1:0];
          reach[v] = 1'b1;
        end
      end
    end
    for (v = 0; v < n; v++) begin
      r.node = dgsp_pkg::OUT_INDEX_BITS'(v);
      r.length = reach[v] ? best_dist[v] : '0;
      r.reach = reach[v];
      r.last_flag = (v == n - 1);
      expected_paths.push_back(r);
    end
  endtask

  task automatic apply_to_graph(input logic [1:0] f, input logic [dgsp_pkg::END_BITS-1:0] a,
                                input logic [dgsp_pkg::END_BITS-1:0] b,
                                input logic [dgsp_pkg::IN_WEIGHT_BITS-1:0] w);
    settle_cycles = ITEM_SETTLE;
    case (f)
      dgsp_pkg::FUNC_CLEAR: begin
        clear_graph_model();
        settle_cycles = CLEAR_SETTLE;
      end
      dgsp_pkg::FUNC_EDGE: begin
        weight_mat[a][b] = w;
        weight_mat[b][a] = w;
      end
      dgsp_pkg::FUNC_RUN: begin
        predict_paths();
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] f, input logic [dgsp_pkg::END_BITS-1:0] a,
                           input logic [dgsp_pkg::END_BITS-1:0] b,
                           input logic [dgsp_pkg::IN_WEIGHT_BITS-1:0] w);
    repeat (pick_gap()) @(negedge clk);
    s_tuser = f;
    s_tdata = {4'b0000, w, b, a};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_to_graph(f, a, b, w);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic cfg_write(input logic idx, input logic [6:0] value);
    while (expected_paths.size() != 0) @(negedge clk);
    repeat (settle_cycles) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == dgsp_pkg::CFG_NODE_COUNT) node_count_reg = value;
    else source_reg = value[dgsp_pkg::SOURCE_BITS-1:0];
    settle_cycles = ITEM_SETTLE;
  endtask

  task automatic test_reset_defaults();
    quiet_phase = 1'b1;
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
    send_item(FUNC_UNUSED, 6'd63, 6'd63, 16'hFFFF);
  endtask

  task automatic test_small_graph();
    quiet_phase = 1'b0;
    cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'd8);
    cfg_write(dgsp_pkg::CFG_SOURCE_NODE, 7'd0);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd0, 6'd1, 16'd5);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd2, 6'd1, 16'd3);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd0, 6'd2, 16'd9);
    // overwrite, now ties with the path through node 1
    send_item(dgsp_pkg::FUNC_EDGE, 6'd2, 6'd0, 16'd8);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd2, 6'd3, 16'hFFFF);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd3, 6'd3, 16'd7);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd4, 6'd5, 16'd1);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd3, 6'd4, 16'd2);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd63, 6'd62, 16'hFFFF);
    send_item(dgsp_pkg::FUNC_EDGE, 6'd62, 6'd63, 16'd1);
    // weight zero removes the edge
    send_item(dgsp_pkg::FUNC_EDGE, 6'd5, 6'd4, 16'd0);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
  endtask

  task automatic test_node_count_limits();
    cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'd0);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
    cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'd127);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
    cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'd1);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
  endtask

  task automatic test_source_outside();
    cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'd6);
    cfg_write(dgsp_pkg::CFG_SOURCE_NODE, 7'd63);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
    cfg_write(dgsp_pkg::CFG_SOURCE_NODE, 7'd5);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
  endtask

  task automatic test_clear_matrix();
    send_item(dgsp_pkg::FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
  endtask

  task automatic test_long_path();
    int i;
    cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'd40);
    cfg_write(dgsp_pkg::CFG_SOURCE_NODE, 7'd0);
    quiet_phase = 1'b1;
    send_item(dgsp_pkg::FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
    for (i = 0; i < 39; i++)
      send_item(dgsp_pkg::FUNC_EDGE, 6'(i), 6'(i + 1),
                16'(16'hFFFF - $urandom_range(0, 15)));
    quiet_phase = 1'b0;
    send_item(dgsp_pkg::FUNC_RUN, 6'd0, 6'd0, 16'd0);
  endtask

  task automatic test_random_graphs();
    int sent, k, e, n;
    logic [dgsp_pkg::END_BITS-1:0] a, b;
    logic [dgsp_pkg::IN_WEIGHT_BITS-1:0] w;
    int pick;
    sent = 0;
    while (sent < 40) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
        cfg_write(dgsp_pkg::CFG_NODE_COUNT, 7'(n));
        if ($urandom_range(0, 6) == 0)
          cfg_write(dgsp_pkg::CFG_SOURCE_NODE, 7'($urandom_range(0, 127)));
        else
          cfg_write(dgsp_pkg::CFG_SOURCE_NODE, 7'($urandom_range(0, n - 1)));
      end
      n = nodes_in_use();
      if ($urandom_range(0, 3) == 0) begin
        send_item(dgsp_pkg::FUNC_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
        sent++;
      end
      k = $urandom_range(3, 12);
      for (e = 0; e < k; e++) begin
        a = ($urandom_range(0, 6) == 0) ? 6'($urandom) : 6'($urandom_range(0, n - 1));
        b = ($urandom_range(0, 6) == 0) ? 6'($urandom) : 6'($urandom_range(0, n - 1));
        pick = $urandom_range(0, 9);
        if (pick < 4) w = 16'($urandom_range(1, 4));
        else if (pick < 8) w = 16'($urandom);
        else if (pick < 9) w = '0;
        else w = 16'(16'hFFFF - $urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
          send_item(FUNC_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
        send_item(dgsp_pkg::FUNC_EDGE, a, b, w);
        sent++;
      end
      send_item(dgsp_pkg::FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
      sent++;
    end
  endtask

  always @(negedge clk) begin
    if (quiet_phase) begin
      m_tready = 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      m_tready = 1'b0;
      ready_hold--;
    end else begin
      ready_hold = pick_gap();
      m_tready = (ready_hold == 0);
      if (ready_hold > 0) ready_hold--;
    end
  end

  always @(posedge clk) begin : check_results
    path_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.node = m_tdata[dgsp_pkg::OUT_INDEX_BITS-1:0];
      got.length = m_tdata[dgsp_pkg::OUT_INDEX_BITS +: dgsp_pkg::DIST_BITS];
      got.reach = m_tuser;
      got.last_flag = m_tlast;
      if (expected_paths.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: node %0d length %0d reach %0b last %0b",
                   got.node, got.length, got.reach, got.last_flag);
        mismatches++;
      end else begin
        want = expected_paths.pop_front();
        if (got.node !== want.node || got.length !== want.length ||
            got.reach !== want.reach || got.last_flag !== want.last_flag) begin
          if (mismatches < 10) begin
            $display("mismatch: expected node %0d length %0d reach %0b last %0b",
                     want.node, want.length, want.reach, want.last_flag);
            $display("          got node %0d length %0d reach %0b last %0b",
                     got.node, got.length, got.reach, got.last_flag);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[dense_graph_shortest_paths_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    clear_graph_model();
    node_count_reg = dgsp_pkg::NODE_COUNT_RESET;
    source_reg = dgsp_pkg::SOURCE_RESET;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    // matrix sweep after reset
    settle_cycles = CLEAR_SETTLE;
    test_reset_defaults();
    test_small_graph();
    test_node_count_limits();
    test_source_outside();
    test_clear_matrix();
    test_long_path();
    test_random_graphs();
    s_tvalid = 1'b0;
    while (expected_paths.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_paths.size() == 0) begin
      $display("[dense_graph_shortest_paths_top] OK");
    end else begin
      $display("[dense_graph_shortest_paths_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/dgsp_pkg.sv
sv/dgsp_ram.sv
sv/dgsp_relax.sv
sv/dense_graph_shortest_paths_top.sv
sv/dgsp_checker.sv
tb/tb_dense_graph_shortest_paths_top.sv
